// File: design/dfdo_pkg.sv
// dfdo_pkg: shared sizes, payload structs, status codes and the
// controller/datapath link types for the datagram fifo with drop-oldest
// no dependencies
package dfdo_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int SLOT_BYTES  = 1024;

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int OFF_W  = $clog2(SLOT_BYTES);
  localparam int ADDR_W = $clog2(QUEUE_DEPTH * SLOT_BYTES);
  localparam int LEN_W  = 16;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  localparam logic [2:0] ST_STORED    = 3'd0;
  localparam logic [2:0] ST_COMMITTED = 3'd1;
  localparam logic [2:0] ST_OVERSIZE  = 3'd2;
  localparam logic [2:0] ST_READ_OK   = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_CAP_SHORT = 3'd5;

  typedef struct packed {
    logic        mode;
    logic [7:0]  data_byte;
    logic [15:0] datagram_length;
    logic        last_in;
    logic [15:0] read_capacity;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last_out;
    logic [15:0] entry_length;
    logic [2:0]  status;
    logic        dropped_oldest;
    logic [8:0]  queue_count;
    logic [31:0] total_queued;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch item and launch memory reads
    logic exec;     // update state and load the result register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;  // result register holds a transfer that is not taken this cycle
  } dp_stat_t;

endpackage

// File: design/dfdo_ctrl.sv
// dfdo_ctrl: two-state controller, capture an item then execute it
// depends on dfdo_pkg
module dfdo_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  dfdo_pkg::dp_stat_t    stat_i,
  output dfdo_pkg::ctrl_cmd_t   cmd_o
);
  import dfdo_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.exec    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait until the result register can take the new result
        if (!stat_i.out_busy) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/dfdo_datapath.sv
// dfdo_datapath: queue pointers, slot byte and length memories, write and
// read step logic and the result register
// depends on dfdo_pkg
module dfdo_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dfdo_pkg::in_t         in_data_i,
  input  dfdo_pkg::ctrl_cmd_t   cmd_i,
  output dfdo_pkg::dp_stat_t    stat_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output dfdo_pkg::out_t        out_data_o
);
  import dfdo_pkg::*;

  localparam logic [LEN_W-1:0] SLOT_LEN = LEN_W'(SLOT_BYTES);
  localparam int DEPTH = QUEUE_DEPTH * SLOT_BYTES;

  // control state
  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [LEN_W-1:0] wo_q, wo_d;
  logic [OFF_W-1:0] ro_q, ro_d;
  logic             skip_q, skip_d;
  logic [31:0]      total_q, total_d;
  logic             out_valid_q;

  // payload
  in_t              item_q;
  logic [LEN_W-1:0] decl_q, decl_d;
  out_t             out_data_q, res;

  // memories
  logic [7:0]       byte_mem [DEPTH];
  logic [LEN_W-1:0] len_mem  [QUEUE_DEPTH];
  logic [7:0]       byte_rdata_q;
  logic [LEN_W-1:0] len_rdata_q;

  logic              byte_we;
  logic [ADDR_W-1:0] byte_waddr, byte_raddr;
  logic              len_we;
  logic [LEN_W-1:0]  len_wdata;

  assign byte_raddr = ADDR_W'(head_q) * ADDR_W'(SLOT_BYTES) + ADDR_W'(ro_q);
  assign byte_waddr = ADDR_W'(tail_q) * ADDR_W'(SLOT_BYTES) + ADDR_W'(wo_q[OFF_W-1:0]);

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] nxt;
    if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = idx + 1'b1;
    end
    return nxt;
  endfunction

  always_comb begin
    logic             first;
    logic             evict;
    logic [LEN_W-1:0] decl;
    logic [LEN_W-1:0] wo_inc;
    logic [CNT_W-1:0] cnt_mid;
    logic [LEN_W:0]   ro_next_ext;

    head_d    = head_q;
    tail_d    = tail_q;
    cnt_d     = cnt_q;
    wo_d      = wo_q;
    ro_d      = ro_q;
    skip_d    = skip_q;
    total_d   = total_q;
    decl_d    = decl_q;
    byte_we   = 1'b0;
    len_we    = 1'b0;
    len_wdata = '0;
    res       = '0;

    first       = (wo_q == '0);
    evict       = 1'b0;
    decl        = first ? item_q.datagram_length : decl_q;
    wo_inc      = (wo_q == '1) ? wo_q : wo_q + 1'b1;
    cnt_mid     = cnt_q;
    ro_next_ext = (LEN_W + 1)'(ro_q) + 1'b1;

    if (item_q.mode == MODE_WRITE) begin
      if (skip_q) begin
        res.status = ST_OVERSIZE;
        if (item_q.last_in) begin
          skip_d = 1'b0;
        end
      end else if (first && (item_q.datagram_length > SLOT_LEN)) begin
        res.status = ST_OVERSIZE;
        skip_d     = ~item_q.last_in;
      end else begin
        decl_d = decl;
        // full queue makes room on the first byte; tail slot does not move
        evict  = first && (cnt_q == CNT_W'(QUEUE_DEPTH));
        if (evict) begin
          head_d  = idx_inc(head_q);
          cnt_mid = cnt_q - 1'b1;
          ro_d    = '0;
        end
        res.dropped_oldest = evict;
        byte_we = (wo_q < decl);
        if (item_q.last_in) begin
          len_we     = 1'b1;
          len_wdata  = (wo_inc < decl) ? wo_inc : decl;
          cnt_d      = cnt_mid + 1'b1;
          total_d    = total_q + 1'b1;
          wo_d       = '0;
          tail_d     = idx_inc(tail_q);
          res.status = ST_COMMITTED;
        end else begin
          cnt_d      = cnt_mid;
          wo_d       = wo_inc;
          res.status = ST_STORED;
        end
      end
    end else begin
      if (cnt_q == '0) begin
        res.status = ST_EMPTY;
      end else begin
        res.entry_length = len_rdata_q;
        if ((ro_q == '0) && (item_q.read_capacity < len_rdata_q)) begin
          res.status = ST_CAP_SHORT;
        end else begin
          res.status = ST_READ_OK;
          // zero-length entry reads as a single zero byte
          if (LEN_W'(ro_q) < len_rdata_q) begin
            res.out_byte = byte_rdata_q;
          end
          if (ro_next_ext >= (LEN_W + 1)'(len_rdata_q)) begin
            res.last_out = 1'b1;
            head_d       = idx_inc(head_q);
            cnt_d        = cnt_q - 1'b1;
            ro_d         = '0;
          end else begin
            ro_d = ro_q + 1'b1;
          end
        end
      end
    end

    res.queue_count  = 9'(cnt_d);
    res.total_queued = total_d;
  end

  // slot memories, read on capture and written on execute
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && byte_we) begin
      byte_mem[byte_waddr] <= item_q.data_byte;
    end
    if (cmd_i.capture) begin
      byte_rdata_q <= byte_mem[byte_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && len_we) begin
      len_mem[tail_q] <= len_wdata;
    end
    if (cmd_i.capture) begin
      len_rdata_q <= len_mem[head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
    if (cmd_i.exec) begin
      decl_q     <= decl_d;
      out_data_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      wo_q        <= '0;
      ro_q        <= '0;
      skip_q      <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        head_q      <= head_d;
        tail_q      <= tail_d;
        cnt_q       <= cnt_d;
        wo_q        <= wo_d;
        ro_q        <= ro_d;
        skip_q      <= skip_d;
        total_q     <= total_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.out_busy = out_valid_q & ~out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;

endmodule

// File: design/datagram_fifo_drop_oldest.sv
// datagram_fifo_drop_oldest: top level, joins the controller and the datapath
// depends on dfdo_pkg, dfdo_ctrl, dfdo_datapath
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_ready_o  | in_data_i  (dfdo_pkg::in_t)
//   out     | output    | out_valid_o / out_ready_i | out_data_o (dfdo_pkg::out_t)
//
// each item is first captured, reading the head length and slot byte from
// the registered memory ports, then executed, updating the queue and loading the result
// reset clears pointers, counters and the result valid; slot memories hold no reset
// a result waiting in the output register does not block the next transfer in;
// execution of that item waits until the result register frees
module datagram_fifo_drop_oldest (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dfdo_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dfdo_pkg::out_t out_data_o
);
  import dfdo_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  dfdo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dfdo_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: sim/dfdo_result_checker.sv
// dfdo_result_checker: watches both channels of the datagram fifo, predicts each result
// from its own copy of the queue state and compares the result transfers in order
// depends on dfdo_pkg
`timescale 1ns / 100ps

module dfdo_result_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  dfdo_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  dfdo_pkg::out_t out_data_i,
  output int            errors_o,
  output int            outstanding_o
);
  import dfdo_pkg::*;

  // predicted queue contents
  logic [7:0]       slot_mem [QUEUE_DEPTH][SLOT_BYTES];
  logic [15:0]      slot_len [QUEUE_DEPTH];
  logic [IDX_W-1:0] head_idx;
  logic [CNT_W-1:0] held;
  logic [15:0]      wr_off;
  logic [15:0]      rd_off;
  logic             skip_rest;
  logic [31:0]      commits;

  out_t awaited_results [$];
  out_t oldest_result;
  out_t fresh_result;

  function automatic logic [IDX_W-1:0] tail_slot();
    return IDX_W'(head_idx + held);
  endfunction

  function automatic void evict_head();
    head_idx = head_idx + 1'b1;
    held     = held - 1'b1;
    rd_off   = '0;
  endfunction

  function automatic out_t fifo_response(input in_t item);
    out_t             res;
    logic [IDX_W-1:0] ws;
    logic [15:0]      decl;
    logic [15:0]      len;
    res = '0;
    if (item.mode == MODE_WRITE) begin
      if (skip_rest) begin
        res.status = ST_OVERSIZE;
        if (item.last_in) skip_rest = 1'b0;
      end else if (wr_off == 0 && item.datagram_length > SLOT_BYTES) begin
        res.status = ST_OVERSIZE;
        if (!item.last_in) skip_rest = 1'b1;
      end else begin
        if (wr_off == 0) begin
          if (held >= QUEUE_DEPTH) begin
            evict_head();
            res.dropped_oldest = 1'b1;
          end
          slot_len[tail_slot()] = item.datagram_length;
        end
        ws   = tail_slot();
        decl = slot_len[ws];
        if (wr_off < decl && wr_off < SLOT_BYTES) begin
          slot_mem[ws][wr_off[OFF_W-1:0]] = item.data_byte;
        end
        if (wr_off != 16'hFFFF) wr_off = wr_off + 1'b1;
        if (item.last_in) begin
          // stored length is whatever actually arrived, capped by the declaration
          slot_len[ws] = (wr_off < decl) ? wr_off : decl;
          held         = held + 1'b1;
          commits      = commits + 1'b1;
          wr_off       = '0;
          res.status   = ST_COMMITTED;
        end else begin
          res.status = ST_STORED;
        end
      end
    end else begin
      if (held == 0) begin
        res.status = ST_EMPTY;
      end else begin
        len              = slot_len[head_idx];
        res.entry_length = len;
        if (rd_off == 0 && item.read_capacity < len) begin
          res.status = ST_CAP_SHORT;
        end else begin
          res.status = ST_READ_OK;
          if (rd_off < len && rd_off < SLOT_BYTES) begin
            res.out_byte = slot_mem[head_idx][rd_off[OFF_W-1:0]];
          end
          if (32'(rd_off) + 1 >= 32'(len)) begin
            res.last_out = 1'b1;
            evict_head();
          end else begin
            rd_off = rd_off + 1'b1;
          end
        end
      end
    end
    res.queue_count  = held;
    res.total_queued = commits;
    return res;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
      errors_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_idx  = '0;
      held      = '0;
      wr_off    = '0;
      rd_off    = '0;
      skip_rest = 1'b0;
      commits   = '0;
      awaited_results.delete();
      errors_o      = 0;
      outstanding_o = 0;
    end else begin
      // compare first so a transfer in this cycle cannot mask a stray result
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing outstanding, status %0d", out_data_i.status);
          errors_o++;
        end else begin
          oldest_result = awaited_results.pop_front();
          check_field("out_byte", 32'(oldest_result.out_byte), 32'(out_data_i.out_byte));
          check_field("last_out", 32'(oldest_result.last_out), 32'(out_data_i.last_out));
          check_field("entry_length", 32'(oldest_result.entry_length),
                      32'(out_data_i.entry_length));
          check_field("status", 32'(oldest_result.status), 32'(out_data_i.status));
          check_field("dropped_oldest", 32'(oldest_result.dropped_oldest),
                      32'(out_data_i.dropped_oldest));
          check_field("queue_count", 32'(oldest_result.queue_count),
                      32'(out_data_i.queue_count));
          check_field("total_queued", oldest_result.total_queued, out_data_i.total_queued);
        end
      end
      if (in_valid_i && in_ready_i) begin
        fresh_result = fifo_response(in_data_i);
        awaited_results.push_back(fresh_result);
      end
      outstanding_o = awaited_results.size();
    end
  end

endmodule

// File: sim/tb_datagram_fifo_drop_oldest.sv
// tb_datagram_fifo_drop_oldest: drives directed and random byte traffic into the
// datagram fifo under several idle patterns and reports the verdict
// depends on dfdo_pkg, datagram_fifo_drop_oldest, dfdo_result_checker
`timescale 1ns / 100ps

module tb_datagram_fifo_drop_oldest;
  import dfdo_pkg::*;

  localparam int ITEMS          = 1100;
  localparam int WATCHDOG_LIMIT = 1500;

  logic clk_i      = 1'b0;
  logic rst_n_q    = 1'b0;
  logic in_valid_q = 1'b0;
  in_t  in_data_q  = '0;
  logic out_ready_q = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_data_o;

  int errors;
  int outstanding;
  int items_sent    = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // open datagram of the random writer
  int          run_left  = 0;
  logic [15:0] run_decl  = '0;
  logic        run_first = 1'b0;

  always #6 clk_i = ~clk_i;

  datagram_fifo_drop_oldest uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n_q),
    .in_valid_i (in_valid_q),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_q),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_q),
    .out_data_o (out_data_o)
  );

  dfdo_result_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_n_q),
    .in_valid_i   (in_valid_q),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_q),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_q),
    .out_data_i   (out_data_o),
    .errors_o     (errors),
    .outstanding_o(outstanding)
  );

  always @(negedge clk_i) begin
    out_ready_q <= ($urandom_range(99) >= stall_pct);
  end

  function automatic in_t write_item(input logic [7:0] b, input logic [15:0] len,
                                     input logic last);
    in_t it;
    it.mode            = MODE_WRITE;
    it.data_byte       = b;
    it.datagram_length = len;
    it.last_in         = last;
    it.read_capacity   = 16'($urandom);
    return it;
  endfunction

  function automatic in_t read_item(input logic [15:0] cap);
    in_t it;
    it.mode            = MODE_READ;
    it.data_byte       = 8'($urandom);
    it.datagram_length = 16'($urandom);
    it.last_in         = 1'($urandom);
    it.read_capacity   = cap;
    return it;
  endfunction

  function automatic logic [15:0] rand_cap();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) return 16'hFFFF;
    if (pick < 80) return 16'($urandom);
    return 16'($urandom_range(0, 8));
  endfunction

  // valid stays up across back-to-back transfers, dropped only for a gap
  task automatic push(input in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_q <= 1'b0;
      @(negedge clk_i);
    end
    in_data_q  <= item;
    in_valid_q <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic push_next_write();
    int kind;
    if (run_left == 0) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        run_decl = 16'($urandom_range(0, 6));
        run_left = (run_decl == 0) ? 1 : int'(run_decl);
      end else if (kind < 75) begin
        // short or long byte run against the declaration
        run_decl = 16'($urandom_range(0, 8));
        run_left = $urandom_range(1, 10);
      end else if (kind < 82) begin
        run_decl = ($urandom_range(3) == 0) ? 16'(SLOT_BYTES) : 16'($urandom_range(9, 1023));
        run_left = $urandom_range(1, 12);
      end else if (kind < 92) begin
        run_decl = ($urandom_range(3) == 0) ? 16'(SLOT_BYTES + 1)
                                            : 16'($urandom_range(SLOT_BYTES + 1, 65535));
        run_left = $urandom_range(1, 4);
      end else begin
        run_decl = 16'($urandom);
        run_left = $urandom_range(1, 3);
      end
      run_first = 1'b1;
    end
    push(write_item(8'($urandom), run_first ? run_decl : 16'($urandom), run_left == 1));
    run_first = 1'b0;
    run_left--;
  endtask

  task automatic wait_drained();
    in_valid_q <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic set_phase(input int p);
    case (p)
      0: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      1: begin
        send_idle_pct = 86;
        stall_pct     = 0;
      end
      2: begin
        send_idle_pct = 0;
        stall_pct     = 86;
      end
      default: begin
        send_idle_pct = 27;
        stall_pct     = 27;
      end
    endcase
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_n_q);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_q && in_ready_o) || (out_valid_o && out_ready_q)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int mixed_start;
    int span;
    int pick;
    int n;
    int read_pct;

    set_phase(0);
    repeat (6) @(negedge clk_i);
    rst_n_q <= 1'b1;
    @(negedge clk_i);

    // directed: empty queue, zero length, oversize, short and long runs, capacity short
    push(read_item(16'd0));
    push(write_item(8'hAA, 16'd0, 1'b1));
    push(read_item(16'd0));
    push(write_item(8'h11, 16'(SLOT_BYTES + 1), 1'b0));
    push(write_item(8'h22, 16'h0000, 1'b1));
    push(write_item(8'h33, 16'hFFFF, 1'b1));
    push(write_item(8'hFF, 16'(SLOT_BYTES), 1'b0));
    push(write_item(8'h00, 16'hFFFF, 1'b0));
    push(write_item(8'h5A, 16'h0000, 1'b1));
    push(write_item(8'hC3, 16'd2, 1'b0));
    push(write_item(8'h3C, 16'd0, 1'b0));
    push(write_item(8'hF0, 16'hFFFF, 1'b0));
    push(write_item(8'h0F, 16'd7, 1'b1));
    push(read_item(16'd2));
    push(read_item(16'd3));
    push(read_item(16'd0));
    push(read_item(16'd0));
    push(read_item(16'hFFFF));
    push(read_item(16'd0));
    push(read_item(16'hFFFF));

    // flood: partly read the head, then overfill so it gets evicted mid-read
    push(write_item(8'h81, 16'd4, 1'b0));
    push(write_item(8'h42, 16'd4, 1'b0));
    push(write_item(8'h24, 16'd4, 1'b0));
    push(write_item(8'h18, 16'd4, 1'b1));
    push(read_item(16'd4));
    push(read_item(16'd4));
    repeat (QUEUE_DEPTH + 2) push(write_item(8'($urandom), 16'($urandom_range(0, 1)), 1'b1));
    repeat (QUEUE_DEPTH + 6) push(read_item(($urandom_range(3) == 0) ? 16'd0 : 16'hFFFF));

    mixed_start = items_sent;
    span        = (ITEMS - mixed_start) / 4;
    phase       = 0;
    while (items_sent < ITEMS) begin
      if (phase < 3 && items_sent - mixed_start >= (phase + 1) * span) begin
        wait_drained();
        phase++;
        set_phase(phase);
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        n        = $urandom_range(10, 40);
        read_pct = $urandom_range(25, 70);
        repeat (n) begin
          if ($urandom_range(99) < read_pct) push(read_item(rand_cap()));
          else push_next_write();
        end
      end else if (pick < 85) begin
        repeat ($urandom_range(5, 30)) push(read_item(rand_cap()));
      end else begin
        repeat ($urandom_range(5, 30)) push_next_write();
      end
    end

    in_valid_q <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
